// ----- rtl/core/arp_cache_table_defines.svh -----
// Assertion macros shared by the ARP cache RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ARP_CACHE_TABLE_DEFINES_SVH
`define ARP_CACHE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ARPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ARPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/arpc_pkg.sv -----
// Shared types and constants of the ARP cache table.
// Depends on nothing.
`default_nettype none

package arpc_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;

  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int STAMP_W  = 16;
  localparam int SLOT_W   = 3;
  localparam int CNT_OUT_W = 4;
  localparam int PADDR_W  = 4;

  localparam logic [IP_W-1:0]    IP_NONE       = '0;
  localparam logic [STAMP_W-1:0] AGE_LIMIT_RST = 16'd120;

  typedef enum logic [1:0] {
    REG_HOST_IP     = 2'd0,
    REG_SUBNET_MASK = 2'd1,
    REG_AGE_LIMIT   = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_LEARN_IP  = 2'd0,
    FUNC_LEARN_ARP = 2'd1,
    FUNC_TICK      = 2'd2,
    FUNC_LOOKUP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STS_IGNORED   = 3'd0,
    STS_REFRESHED = 3'd1,
    STS_INSERTED  = 3'd2,
    STS_REPLACED  = 3'd3,
    STS_HIT       = 3'd4,
    STS_MISS      = 3'd5,
    STS_TICK_DONE = 3'd6,
    STS_SPARE     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2,
    ST_SPARE  = 2'd3
  } state_t;

  typedef struct packed {
    logic busy;
    logic accept;
    logic scan;
    logic finish;
  } seq_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/arp_cache_table.sv -----
// ARP cache table: IPv4-to-MAC mapping store with aging and oldest-entry replacement.
// Depends on arpc_pkg and arp_cache_table_defines.svh.
//
//   Channel   Direction  Handshake                     Payload
//   request   in         start high while busy low     in_func, in_ip_addr, in_mac_addr,
//                                                      in_target_ip
//   result    out        out_valid, one-cycle strobe   out_status, out_slot, out_mac_out,
//                                                      out_expired_count
//   config    in/out     APB write at psel&penable     paddr, pwdata, prdata
//
// A request with real table work runs from accept to the next possible accept through a
// sweep that reads each entry in turn through the table memories, a last sweep step that
// checks the registered read of the last entry, and a finish cycle that writes the table
// and loads the result registers. A request that is ignored (IP zero, failed subnet or
// target check) skips the sweep and goes straight to the finish cycle. The result strobe
// rises in the cycle after the finish cycle, while busy is already low, so a new request
// can be taken alongside it. The receiver cannot stall the result. rst_n is synchronous;
// it frees every entry, zeroes the time and restores the register defaults.
`default_nettype none

`include "arp_cache_table_defines.svh"

module arp_cache_table #(
  parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_func,
  input  wire logic [arpc_pkg::IP_W-1:0]       in_ip_addr,
  input  wire logic [arpc_pkg::MAC_W-1:0]      in_mac_addr,
  input  wire logic [arpc_pkg::IP_W-1:0]       in_target_ip,
  // result channel
  output logic                                 out_valid,
  output logic [2:0]                           out_status,
  output logic [arpc_pkg::SLOT_W-1:0]          out_slot,
  output logic [arpc_pkg::MAC_W-1:0]           out_mac_out,
  output logic [arpc_pkg::CNT_OUT_W-1:0]       out_expired_count,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [arpc_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int STEP_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TABLE_ENTRIES);

  // Configuration registers.
  logic [arpc_pkg::IP_W-1:0]    host_ip_r;
  logic [arpc_pkg::IP_W-1:0]    subnet_mask_r;
  logic [arpc_pkg::STAMP_W-1:0] age_limit_r;
  arpc_pkg::reg_idx_t           cfg_idx;
  logic                         cfg_wr;

  // Sequencer.
  arpc_pkg::state_t   state_r, state_nxt;
  arpc_pkg::seq_ctl_t ctl;

  // Table state: valid bits in flops; IP, MAC and stamp in one-write, one-read memories.
  logic [TABLE_ENTRIES-1:0]     valid_r, valid_nxt;
  logic [arpc_pkg::STAMP_W-1:0] now_r, now_nxt;
  logic [arpc_pkg::IP_W-1:0]    ip_mem    [TABLE_ENTRIES];
  logic [arpc_pkg::MAC_W-1:0]   mac_mem   [TABLE_ENTRIES];
  logic [arpc_pkg::STAMP_W-1:0] stamp_mem [TABLE_ENTRIES];
  logic [arpc_pkg::IP_W-1:0]    ip_rd_r;
  logic [arpc_pkg::MAC_W-1:0]   mac_rd_r;
  logic [arpc_pkg::STAMP_W-1:0] stamp_rd_r;
  logic                         mem_we;
  logic                         mem_we_ip;
  logic [IDX_W-1:0]             wr_idx;
  logic [IDX_W-1:0]             rd_addr;

  // Latched request.
  arpc_pkg::func_t              req_func_r, req_func_nxt;
  logic [arpc_pkg::IP_W-1:0]    req_ip_r, req_ip_nxt;
  logic [arpc_pkg::MAC_W-1:0]   req_mac_r, req_mac_nxt;
  logic                         req_ign_r, req_ign_nxt;
  logic                         in_ignore;

  // Sweep bookkeeping.
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic                         chk_vld_r;
  logic [IDX_W-1:0]             chk_idx_r;
  logic                         hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]             hit_idx_r, hit_idx_nxt;
  logic [arpc_pkg::MAC_W-1:0]   hit_mac_r, hit_mac_nxt;
  logic                         free_found_r, free_found_nxt;
  logic [IDX_W-1:0]             free_idx_r, free_idx_nxt;
  logic [arpc_pkg::STAMP_W-1:0] best_age_r, best_age_nxt;
  logic [IDX_W-1:0]             best_idx_r, best_idx_nxt;
  logic [STEP_W-1:0]            exp_cnt_r, exp_cnt_nxt;
  logic [arpc_pkg::STAMP_W-1:0] chk_age;
  logic                         chk_used;

  // Result registers.
  logic                           out_valid_r;
  arpc_pkg::status_t              out_status_r, out_status_nxt;
  logic [arpc_pkg::SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [arpc_pkg::MAC_W-1:0]     out_mac_r, out_mac_nxt;
  logic [arpc_pkg::CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  // ---------------------------------------------------------------------------------------
  // Configuration port. Registers sit at byte addresses 0, 4 and 8; the read is
  // combinational and the port never waits.
  // ---------------------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = arpc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      arpc_pkg::REG_HOST_IP:     prdata = host_ip_r;
      arpc_pkg::REG_SUBNET_MASK: prdata = subnet_mask_r;
      arpc_pkg::REG_AGE_LIMIT:   prdata = {16'd0, age_limit_r};
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Request screening. A tick is always taken. A learn or lookup with IP zero is dropped,
  // as is a learn from an IP packet off the local subnet or an ARP reply not aimed at us.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    in_ignore = 1'b0;
    if (arpc_pkg::func_t'(in_func) != arpc_pkg::FUNC_TICK) begin
      if (in_ip_addr == arpc_pkg::IP_NONE) begin
        in_ignore = 1'b1;
      end else if (arpc_pkg::func_t'(in_func) == arpc_pkg::FUNC_LEARN_IP) begin
        in_ignore = (in_ip_addr & subnet_mask_r) != (host_ip_r & subnet_mask_r);
      end else if (arpc_pkg::func_t'(in_func) == arpc_pkg::FUNC_LEARN_ARP) begin
        in_ignore = in_target_ip != host_ip_r;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer: IDLE takes a request and skips SCAN for an ignored one, SCAN sweeps
  // every entry once through the shared compare path, FINISH writes the table and
  // loads the result.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arpc_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = in_ignore ? arpc_pkg::ST_FINISH : arpc_pkg::ST_SCAN;
        end
      end
      arpc_pkg::ST_SCAN: begin
        if (step_r == STEP_LAST) begin
          state_nxt = arpc_pkg::ST_FINISH;
        end
      end
      arpc_pkg::ST_FINISH: state_nxt = arpc_pkg::ST_IDLE;
      default:             state_nxt = arpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      arpc_pkg::ST_IDLE:   ctl.accept = start;
      arpc_pkg::ST_SCAN: begin
        ctl.busy = 1'b1;
        ctl.scan = 1'b1;
      end
      arpc_pkg::ST_FINISH: begin
        ctl.busy   = 1'b1;
        ctl.finish = 1'b1;
      end
      default:             ctl.busy = 1'b1;
    endcase
  end

  assign busy = ctl.busy;

  // ---------------------------------------------------------------------------------------
  // Datapath. During the sweep, step_r addresses the memories and the entry read in the
  // previous cycle is checked: expiry for a tick; match, first free entry and greatest
  // modular age for a learn or lookup.
  // ---------------------------------------------------------------------------------------
  assign rd_addr  = (step_r < STEP_LAST) ? step_r[IDX_W-1:0] : '0;
  assign chk_age  = now_r - stamp_rd_r;
  assign chk_used = valid_r[chk_idx_r];

  always_comb begin
    req_func_nxt   = req_func_r;
    req_ip_nxt     = req_ip_r;
    req_mac_nxt    = req_mac_r;
    req_ign_nxt    = req_ign_r;
    step_nxt       = step_r;
    now_nxt        = now_r;
    valid_nxt      = valid_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_mac_nxt    = hit_mac_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_age_nxt   = best_age_r;
    best_idx_nxt   = best_idx_r;
    exp_cnt_nxt    = exp_cnt_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_mac_nxt    = out_mac_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we         = 1'b0;
    mem_we_ip      = 1'b0;
    wr_idx         = best_idx_r;

    if (ctl.accept) begin
      req_func_nxt   = arpc_pkg::func_t'(in_func);
      req_ip_nxt     = in_ip_addr;
      req_mac_nxt    = in_mac_addr;
      req_ign_nxt    = in_ignore;
      step_nxt       = '0;
      hit_found_nxt  = 1'b0;
      hit_idx_nxt    = '0;
      hit_mac_nxt    = '0;
      free_found_nxt = 1'b0;
      free_idx_nxt   = '0;
      best_age_nxt   = '0;
      best_idx_nxt   = '0;
      exp_cnt_nxt    = '0;
      // The time advances before the sweep, so ages are measured against the new time.
      if (arpc_pkg::func_t'(in_func) == arpc_pkg::FUNC_TICK) begin
        now_nxt = now_r + 1'b1;
      end
    end

    if (ctl.scan) begin
      step_nxt = step_r + 1'b1;
    end

    if (chk_vld_r) begin
      if (req_func_r == arpc_pkg::FUNC_TICK) begin
        if (chk_used && (chk_age >= age_limit_r)) begin
          valid_nxt[chk_idx_r] = 1'b0;
          exp_cnt_nxt          = exp_cnt_r + 1'b1;
        end
      end else begin
        if (chk_used && (ip_rd_r == req_ip_r) && !hit_found_r) begin
          hit_found_nxt = 1'b1;
          hit_idx_nxt   = chk_idx_r;
          hit_mac_nxt   = mac_rd_r;
        end
        if (!chk_used && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = chk_idx_r;
        end
        // Strictly greater keeps the first entry on ties; only used when all are valid.
        if (chk_age > best_age_r) begin
          best_age_nxt = chk_age;
          best_idx_nxt = chk_idx_r;
        end
      end
    end

    if (ctl.finish) begin
      out_status_nxt = arpc_pkg::STS_IGNORED;
      out_slot_nxt   = '0;
      out_mac_nxt    = '0;
      out_cnt_nxt    = '0;
      if (!req_ign_r) begin
        case (req_func_r)
          arpc_pkg::FUNC_TICK: begin
            out_status_nxt = arpc_pkg::STS_TICK_DONE;
            out_cnt_nxt    = arpc_pkg::CNT_OUT_W'(exp_cnt_r);
          end
          arpc_pkg::FUNC_LOOKUP: begin
            if (hit_found_r) begin
              out_status_nxt = arpc_pkg::STS_HIT;
              out_slot_nxt   = arpc_pkg::SLOT_W'(hit_idx_r);
              out_mac_nxt    = hit_mac_r;
            end else begin
              out_status_nxt = arpc_pkg::STS_MISS;
            end
          end
          default: begin
            // Both learn kinds: refresh the match, else fill the first free entry,
            // else replace the oldest one.
            mem_we = 1'b1;
            if (hit_found_r) begin
              wr_idx         = hit_idx_r;
              out_status_nxt = arpc_pkg::STS_REFRESHED;
            end else if (free_found_r) begin
              wr_idx         = free_idx_r;
              mem_we_ip      = 1'b1;
              out_status_nxt = arpc_pkg::STS_INSERTED;
            end else begin
              wr_idx         = best_idx_r;
              mem_we_ip      = 1'b1;
              out_status_nxt = arpc_pkg::STS_REPLACED;
            end
            valid_nxt[wr_idx] = 1'b1;
            out_slot_nxt      = arpc_pkg::SLOT_W'(wr_idx);
          end
        endcase
      end
    end
  end

  // Table memories: one write port at wr_idx, one registered read port at rd_addr.
  always_ff @(posedge clk) begin
    if (mem_we_ip) begin
      ip_mem[wr_idx] <= req_ip_r;
    end
    if (mem_we) begin
      mac_mem[wr_idx]   <= req_mac_r;
      stamp_mem[wr_idx] <= now_r;
    end
    ip_rd_r    <= ip_mem[rd_addr];
    mac_rd_r   <= mac_mem[rd_addr];
    stamp_rd_r <= stamp_mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= arpc_pkg::ST_IDLE;
      valid_r       <= '0;
      now_r         <= '0;
      out_valid_r   <= 1'b0;
      chk_vld_r     <= 1'b0;
      step_r        <= '0;
      hit_found_r   <= 1'b0;
      free_found_r  <= 1'b0;
      req_ign_r     <= 1'b0;
      host_ip_r     <= '0;
      subnet_mask_r <= '0;
      age_limit_r   <= arpc_pkg::AGE_LIMIT_RST;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      now_r        <= now_nxt;
      out_valid_r  <= ctl.finish;
      chk_vld_r    <= ctl.scan && (step_r < STEP_LAST);
      step_r       <= step_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      req_ign_r    <= req_ign_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          arpc_pkg::REG_HOST_IP:     host_ip_r     <= pwdata;
          arpc_pkg::REG_SUBNET_MASK: subnet_mask_r <= pwdata;
          arpc_pkg::REG_AGE_LIMIT:   age_limit_r   <= pwdata[15:0];
          default:                   ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chk_idx_r    <= rd_addr;
    req_func_r   <= req_func_nxt;
    req_ip_r     <= req_ip_nxt;
    req_mac_r    <= req_mac_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_mac_r    <= hit_mac_nxt;
    free_idx_r   <= free_idx_nxt;
    best_age_r   <= best_age_nxt;
    best_idx_r   <= best_idx_nxt;
    exp_cnt_r    <= exp_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_mac_r    <= out_mac_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_mac_out       = out_mac_r;
  assign out_expired_count = out_cnt_r;

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  `ARPC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `ARPC_ASSERT_NXT(a_finish_result, state_r == arpc_pkg::ST_FINISH,
                   out_valid_r && (state_r == arpc_pkg::ST_IDLE), "finish gave no result")
  `ARPC_ASSERT_IMP(a_result_idle, out_valid_r, !busy, "result strobe while busy")
  `ARPC_ASSERT_IMP(a_miss_no_mac, out_valid_r && (out_status_r != arpc_pkg::STS_HIT),
                   out_mac_r == '0, "MAC reported without a hit")
  `ARPC_ASSERT_IMP(a_step_range, state_r == arpc_pkg::ST_SCAN, step_r <= STEP_LAST,
                   "sweep ran past the table")

endmodule

`default_nettype wire
